@@ design/surface_newton_step_solver_defines.svh @@
`ifndef SURFACE_NEWTON_STEP_SOLVER_DEFINES_SVH
`define SURFACE_NEWTON_STEP_SOLVER_DEFINES_SVH

// same-cycle implication
`define SNSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SNSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/snss_pkg.sv @@
`timescale 1ns / 1ps

package snss_pkg;

    localparam int SPACE_DIM = 3;

    localparam int CRD_W   = 32;
    localparam int FRAC    = 16;
    localparam int CFG_AW  = 3;
    localparam int TOL_W   = 31;
    localparam int DTOL_SH = 48;

    localparam int LIMB_W  = 22;
    localparam int T_W     = 3 * LIMB_W;
    localparam int MUL_W   = 2 * T_W;
    localparam int MUL_LAT = 5;

    localparam int NUMS_W  = MUL_W + 1;
    localparam int NUM_W   = NUMS_W + FRAC;
    localparam int DEN_W   = 128;
    localparam int DIV_QB  = 31;
    localparam int REM_W   = DEN_W + DIV_QB + 1;
    localparam int DIV_LAT = DIV_QB + 2;

    localparam int SQ_STEPS = 32;
    localparam int SQ_RW    = SQ_STEPS + 4;

    localparam int STG_SUM  = 4;
    localparam int STG_SEL  = 11;
    localparam int OUT_STG  = STG_SEL + DIV_LAT;
    localparam int SQ_END   = STG_SUM + SQ_STEPS;
    localparam int DIST_DLY = OUT_STG - SQ_END;

    localparam logic signed [CRD_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [CRD_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic {
        REG_GEOM_TOL = 1'b0,
        REG_DET_TOL  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_div_ctl;

    typedef struct packed {
        logic        [63:0]    t1;
        logic        [63:0]    t3;
        logic signed [T_W-1:0] t4;
        logic signed [T_W-1:0] t5;
        logic                  short1;
        logic                  short3;
        logic                  t3gt;
    } t_side;

endpackage

@@ design/snss_mul.sv @@
`timescale 1ns / 1ps

module snss_mul (
    input  logic                               i_clk,
    input  logic signed [snss_pkg::T_W-1:0]    i_a,
    input  logic signed [snss_pkg::T_W-1:0]    i_b,
    output logic signed [snss_pkg::MUL_W-1:0]  o_p
);

    localparam int LW = snss_pkg::LIMB_W;

    logic [snss_pkg::T_W-1:0]   r1_ma, r1_mb;
    logic                       r1_sg, r2_sg, r3_sg, r4_sg;
    logic [2*LW-1:0]            r2_pp [0:2][0:2];
    logic [4*LW-1:0]            r3_row [0:2];
    logic [snss_pkg::MUL_W-1:0] r4_mag;

    always_ff @(posedge i_clk) begin
        r1_ma <= i_a[snss_pkg::T_W-1] ? snss_pkg::T_W'(-i_a) : snss_pkg::T_W'(i_a);
        r1_mb <= i_b[snss_pkg::T_W-1] ? snss_pkg::T_W'(-i_b) : snss_pkg::T_W'(i_b);
        r1_sg <= i_a[snss_pkg::T_W-1] ^ i_b[snss_pkg::T_W-1];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r2_pp[i][j] <= r1_ma[i*LW +: LW] * r1_mb[j*LW +: LW];
            end
        end
        r2_sg <= r1_sg;
        for (int i = 0; i < 3; i++) begin
            r3_row[i] <= (4*LW)'(r2_pp[i][0])
                       + ((4*LW)'(r2_pp[i][1]) << LW)
                       + ((4*LW)'(r2_pp[i][2]) << (2*LW));
        end
        r3_sg  <= r2_sg;
        r4_mag <= snss_pkg::MUL_W'(r3_row[0])
                + (snss_pkg::MUL_W'(r3_row[1]) << LW)
                + (snss_pkg::MUL_W'(r3_row[2]) << (2*LW));
        r4_sg  <= r3_sg;
        o_p    <= r4_sg ? -$signed(r4_mag) : $signed(r4_mag);
    end

endmodule

@@ design/snss_div.sv @@
`timescale 1ns / 1ps
`include "surface_newton_step_solver_defines.svh"

module snss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [snss_pkg::NUM_W-1:0]        i_num,
    input  logic [snss_pkg::DEN_W-1:0]        i_den,
    input  snss_pkg::t_div_ctl                i_ctl,
    output logic                              o_valid,
    output logic signed [snss_pkg::CRD_W-1:0] o_quot
);

    localparam int QB = snss_pkg::DIV_QB;
    localparam int RW = snss_pkg::REM_W;

    logic                       r_vld [0:QB];
    logic [RW-1:0]              r_rem [0:QB];
    logic [snss_pkg::DEN_W-1:0] r_den [0:QB];
    logic [QB-1:0]              r_q   [0:QB];
    logic                       r_sat [0:QB];
    snss_pkg::t_div_ctl         r_ctl [0:QB];

    logic [RW-1:0] w_rem0, w_lim;

    assign w_rem0 = RW'(i_num);
    assign w_lim  = RW'(i_den) << QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_rem0;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_sat[0] <= (w_rem0 >= w_lim);
        r_ctl[0] <= i_ctl;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [RW-1:0] w_sh;
        logic          w_take;

        assign w_sh   = RW'(r_den[k-1]) << (QB - k);
        assign w_take = !r_sat[k-1] && (r_rem[k-1] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_take ? r_rem[k-1] - w_sh : r_rem[k-1];
            r_q[k]   <= r_q[k-1] | (w_take ? (QB'(1) << (QB - k)) : QB'(0));
            r_den[k] <= r_den[k-1];
            r_sat[k] <= r_sat[k-1];
            r_ctl[k] <= r_ctl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl[QB].zero) begin
            o_quot <= '0;
        end else if (r_sat[QB]) begin
            o_quot <= r_ctl[QB].neg ? snss_pkg::Q_MIN : snss_pkg::Q_MAX;
        end else if (r_ctl[QB].neg) begin
            o_quot <= -$signed({1'b0, r_q[QB]});
        end else begin
            o_quot <= $signed({1'b0, r_q[QB]});
        end
    end

    `SNSS_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, r_vld[QB] && !r_sat[QB], r_rem[QB] < RW'(r_den[QB]), "remainder not below divisor")
    `SNSS_ASSERT_NEXT(a_zero_quot, i_clk, i_rst_n, r_vld[QB] && r_ctl[QB].zero, o_quot == '0, "forced zero step not zero")

endmodule

@@ design/surface_newton_step_solver.sv @@
`timescale 1ns / 1ps
`include "surface_newton_step_solver_defines.svh"

// channel   direction  handshake                       beat
// command   in         start & !busy                   target, surface point, two tangents
// result    out        o_done, one cycle               distance, step_u, step_v, degenerate
// config    in         psel & penable & pwrite (apb)   geometry / determinant tolerance
//
// one beat accepted per cycle, busy stays low
// results pass the 5-stage wide multipliers, then the 31-step quotient pipe
// distance comes from a 32-step square root pipe running alongside
// synchronous reset clears valid bits and sets the tolerances to 1 and 0
// no stall on either side: results are strobed and taken as they leave

module surface_newton_step_solver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [snss_pkg::CFG_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_target_x,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_target_y,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_target_z,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_surf_x,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_surf_y,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_surf_z,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_du_x,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_du_y,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_du_z,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_dv_x,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_dv_y,
    input  logic signed [snss_pkg::CRD_W-1:0]  i_dv_z,
    output logic                               o_done,
    output logic [snss_pkg::CRD_W-1:0]         o_distance,
    output logic signed [snss_pkg::CRD_W-1:0]  o_step_u,
    output logic signed [snss_pkg::CRD_W-1:0]  o_step_v,
    output logic                               o_degenerate
);

    localparam int CW = snss_pkg::CRD_W;
    localparam int NS = snss_pkg::NUMS_W;
    localparam int DW = snss_pkg::DEN_W;
    localparam int MW = snss_pkg::MUL_W;
    localparam int TW = snss_pkg::T_W;

    logic                    w_acc, w_cfg_wr;
    logic [snss_pkg::TOL_W-1:0] r_geom_tol, r_det_tol;
    logic [snss_pkg::STG_SEL:1] r_v;

    logic signed [CW-1:0] w_tgt [0:2], w_srf [0:2], w_a [0:2], w_b [0:2];
    logic signed [CW-1:0] r1_tgt [0:2], r1_srf [0:2], r1_a [0:2], r1_b [0:2];
    logic signed [CW:0]   r2_p [0:2];
    logic signed [CW-1:0] r2_a [0:2], r2_b [0:2];

    logic signed [63:0]   w_aa [0:2], w_bb [0:2], w_ab [0:2];
    logic signed [64:0]   w_pa [0:2], w_pb [0:2];
    logic signed [65:0]   w_pp [0:2];
    logic [63:0]          r3_aa [0:2], r3_bb [0:2], r3_pp [0:2];
    logic signed [63:0]   r3_ab [0:2], r3_pa [0:2], r3_pb [0:2];

    logic [63:0]          w_t1, w_t3, r4_t1, r4_t3;
    logic signed [64:0]   w_t2, r4_t2;
    logic signed [TW-1:0] w_t4, w_t5, r4_t4, r4_t5;
    logic [65:0]          w_dsq, r4_dsq;
    logic [61:0]          r_tol2;

    logic signed [MW-1:0] w_det1, w_det2, w_n1a, w_n1b, w_n2a, w_n2b, w_det_full;
    logic signed [NS-1:0] w_n1, w_n2;
    snss_pkg::t_side      r_sd [0:snss_pkg::MUL_LAT-1];
    snss_pkg::t_side      r10_sd;
    logic [DW-1:0]        r10_det;
    logic signed [NS-1:0] r10_n1, r10_n2;

    logic                 w_detz, w_base, w_tiny;
    logic signed [NS-1:0] w_num_u, w_num_v;
    logic [NS-1:0]        w_mag_u, w_mag_v;
    logic [snss_pkg::NUM_W-1:0] r11_num_u, r11_num_v;
    logic [DW-1:0]        r11_den_u, r11_den_v;
    snss_pkg::t_div_ctl   r11_ctl_u, r11_ctl_v;
    logic                 r11_degen;

    logic                 r_dg [0:snss_pkg::DIV_LAT-1];
    logic                 w_v_done;

    logic [snss_pkg::SQ_RW-1:0]      r_sq_rem  [0:snss_pkg::SQ_STEPS-1];
    logic [snss_pkg::SQ_STEPS-1:0]   r_sq_root [0:snss_pkg::SQ_STEPS-1];
    logic [2*snss_pkg::SQ_STEPS-1:0] r_sq_x    [0:snss_pkg::SQ_STEPS-1];
    logic                            r_sq_ov   [0:snss_pkg::SQ_STEPS-1];
    logic [CW-1:0]                   r_dist    [0:snss_pkg::DIST_DLY-1];

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_acc    = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (snss_pkg::t_reg_idx'(paddr[2]))
            snss_pkg::REG_GEOM_TOL: prdata = {1'b0, r_geom_tol};
            snss_pkg::REG_DET_TOL:  prdata = {1'b0, r_det_tol};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_tol <= snss_pkg::TOL_W'(1);
            r_det_tol  <= '0;
            r_v        <= '0;
        end else begin
            if (w_cfg_wr) begin
                unique case (snss_pkg::t_reg_idx'(paddr[2]))
                    snss_pkg::REG_GEOM_TOL: r_geom_tol <= pwdata[snss_pkg::TOL_W-1:0];
                    snss_pkg::REG_DET_TOL:  r_det_tol  <= pwdata[snss_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            r_v <= {r_v[snss_pkg::STG_SEL-1:1], w_acc};
        end
    end

    assign w_tgt[0] = i_target_x;
    assign w_tgt[1] = i_target_y;
    assign w_tgt[2] = i_target_z;
    assign w_srf[0] = i_surf_x;
    assign w_srf[1] = i_surf_y;
    assign w_srf[2] = i_surf_z;
    assign w_a[0]   = i_du_x;
    assign w_a[1]   = i_du_y;
    assign w_a[2]   = i_du_z;
    assign w_b[0]   = i_dv_x;
    assign w_b[1]   = i_dv_y;
    assign w_b[2]   = i_dv_z;

    // component products
    for (genvar i = 0; i < 3; i++) begin : g_comp
        assign w_aa[i] = r2_a[i] * r2_a[i];
        assign w_bb[i] = r2_b[i] * r2_b[i];
        assign w_ab[i] = r2_a[i] * r2_b[i];
        assign w_pa[i] = r2_p[i] * r2_a[i];
        assign w_pb[i] = r2_p[i] * r2_b[i];
        assign w_pp[i] = r2_p[i] * r2_p[i];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_tgt[i] <= w_tgt[i];
            r1_srf[i] <= w_srf[i];
            r1_a[i]   <= w_a[i];
            r1_b[i]   <= w_b[i];
            r2_p[i]   <= {r1_tgt[i][CW-1], r1_tgt[i]} - {r1_srf[i][CW-1], r1_srf[i]};
            r2_a[i]   <= r1_a[i];
            r2_b[i]   <= r1_b[i];
            r3_aa[i]  <= w_aa[i];
            r3_bb[i]  <= w_bb[i];
            r3_ab[i]  <= w_ab[i];
            r3_pa[i]  <= w_pa[i][63:0];
            r3_pb[i]  <= w_pb[i][63:0];
            r3_pp[i]  <= w_pp[i][63:0];
        end
    end

    always_comb begin
        w_t1  = '0;
        w_t3  = '0;
        w_t2  = '0;
        w_t4  = '0;
        w_t5  = '0;
        w_dsq = '0;
        for (int i = 0; i < snss_pkg::SPACE_DIM; i++) begin
            w_t1  = w_t1 + r3_aa[i];
            w_t3  = w_t3 + r3_bb[i];
            w_t2  = w_t2 + 65'(r3_ab[i]);
            w_t4  = w_t4 + TW'(r3_pa[i]);
            w_t5  = w_t5 + TW'(r3_pb[i]);
            w_dsq = w_dsq + 66'(r3_pp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_t1  <= w_t1;
        r4_t3  <= w_t3;
        r4_t2  <= w_t2;
        r4_t4  <= w_t4;
        r4_t5  <= w_t5;
        r4_dsq <= w_dsq;
        r_tol2 <= r_geom_tol * r_geom_tol;
    end

    snss_mul u_det1 (.i_clk, .i_a($signed({2'b00, r4_t1})), .i_b($signed({2'b00, r4_t3})),
                     .o_p(w_det1));
    snss_mul u_det2 (.i_clk, .i_a(TW'(r4_t2)), .i_b(TW'(r4_t2)), .o_p(w_det2));
    snss_mul u_n1a  (.i_clk, .i_a(r4_t4), .i_b($signed({2'b00, r4_t3})), .o_p(w_n1a));
    snss_mul u_n1b  (.i_clk, .i_a(r4_t5), .i_b(TW'(r4_t2)), .o_p(w_n1b));
    snss_mul u_n2a  (.i_clk, .i_a($signed({2'b00, r4_t1})), .i_b(r4_t5), .o_p(w_n2a));
    snss_mul u_n2b  (.i_clk, .i_a(TW'(r4_t2)), .i_b(r4_t4), .o_p(w_n2b));

    always_ff @(posedge i_clk) begin
        r_sd[0].t1     <= r4_t1;
        r_sd[0].t3     <= r4_t3;
        r_sd[0].t4     <= r4_t4;
        r_sd[0].t5     <= r4_t5;
        r_sd[0].short1 <= r4_t1 < 64'(r_tol2);
        r_sd[0].short3 <= r4_t3 < 64'(r_tol2);
        r_sd[0].t3gt   <= r4_t3 > 64'(r_tol2);
        for (int k = 1; k < snss_pkg::MUL_LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // gram determinant and cramer numerators
    assign w_det_full = w_det1 - w_det2;
    assign w_n1       = NS'(w_n1a) - NS'(w_n1b);
    assign w_n2       = NS'(w_n2a) - NS'(w_n2b);

    always_ff @(posedge i_clk) begin
        r10_sd  <= r_sd[snss_pkg::MUL_LAT-1];
        r10_det <= w_det_full[DW-1:0];
        r10_n1  <= w_n1;
        r10_n2  <= w_n2;
    end

    assign w_detz  = (r10_det == '0);
    assign w_base  = r10_sd.short1 || r10_sd.short3 || w_detz;
    assign w_tiny  = !w_base && (r10_det < DW'({r_det_tol, {snss_pkg::DTOL_SH{1'b0}}}));
    assign w_num_u = w_base ? NS'(r10_sd.t4) : r10_n1;
    assign w_num_v = w_base ? NS'(r10_sd.t5) : r10_n2;
    assign w_mag_u = w_num_u[NS-1] ? -w_num_u : w_num_u;
    assign w_mag_v = w_num_v[NS-1] ? -w_num_v : w_num_v;

    always_ff @(posedge i_clk) begin
        r11_num_u      <= {w_mag_u, {snss_pkg::FRAC{1'b0}}};
        r11_num_v      <= {w_mag_v, {snss_pkg::FRAC{1'b0}}};
        r11_den_u      <= w_base ? DW'(r10_sd.t1) : r10_det;
        r11_den_v      <= w_base ? DW'(r10_sd.t3) : r10_det;
        r11_ctl_u.neg  <= w_num_u[NS-1];
        r11_ctl_v.neg  <= w_num_v[NS-1];
        r11_ctl_u.zero <= w_base ? (r10_sd.short1 || r10_sd.t1 == '0) : w_tiny;
        r11_ctl_v.zero <= w_base ? !(r10_sd.short1 && r10_sd.t3gt) : w_tiny;
        r11_degen      <= w_base || w_tiny;
    end

    snss_div u_div_u (
        .i_clk, .i_rst_n,
        .i_valid (r_v[snss_pkg::STG_SEL]),
        .i_num   (r11_num_u),
        .i_den   (r11_den_u),
        .i_ctl   (r11_ctl_u),
        .o_valid (o_done),
        .o_quot  (o_step_u)
    );

    snss_div u_div_v (
        .i_clk, .i_rst_n,
        .i_valid (r_v[snss_pkg::STG_SEL]),
        .i_num   (r11_num_v),
        .i_den   (r11_den_v),
        .i_ctl   (r11_ctl_v),
        .o_valid (w_v_done),
        .o_quot  (o_step_v)
    );

    always_ff @(posedge i_clk) begin
        r_dg[0] <= r11_degen;
        for (int k = 1; k < snss_pkg::DIV_LAT; k++) begin
            r_dg[k] <= r_dg[k-1];
        end
    end

    assign o_degenerate = r_dg[snss_pkg::DIV_LAT-1];

    // digit-by-digit square root, two radicand bits a stage
    for (genvar j = 0; j < snss_pkg::SQ_STEPS; j++) begin : g_sqrt
        logic [snss_pkg::SQ_RW-1:0]      w_prem, w_rin, w_trial;
        logic [snss_pkg::SQ_STEPS-1:0]   w_proot;
        logic [2*snss_pkg::SQ_STEPS-1:0] w_px;
        logic                            w_pov, w_ge;

        if (j == 0) begin : g_first
            assign w_prem  = '0;
            assign w_proot = '0;
            assign w_px    = r4_dsq[2*snss_pkg::SQ_STEPS-1:0];
            assign w_pov   = |r4_dsq[65:2*snss_pkg::SQ_STEPS];
        end else begin : g_next
            assign w_prem  = r_sq_rem[j-1];
            assign w_proot = r_sq_root[j-1];
            assign w_px    = r_sq_x[j-1];
            assign w_pov   = r_sq_ov[j-1];
        end

        assign w_rin   = {w_prem[snss_pkg::SQ_RW-3:0],
                          w_px[2*snss_pkg::SQ_STEPS-1:2*snss_pkg::SQ_STEPS-2]};
        assign w_trial = {2'b00, w_proot, 2'b01};
        assign w_ge    = (w_rin >= w_trial);

        always_ff @(posedge i_clk) begin
            r_sq_rem[j]  <= w_ge ? w_rin - w_trial : w_rin;
            r_sq_root[j] <= {w_proot[snss_pkg::SQ_STEPS-2:0], w_ge};
            r_sq_x[j]    <= w_px << 2;
            r_sq_ov[j]   <= w_pov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist[0] <= r_sq_ov[snss_pkg::SQ_STEPS-1] ? '1 : r_sq_root[snss_pkg::SQ_STEPS-1];
        for (int k = 1; k < snss_pkg::DIST_DLY; k++) begin
            r_dist[k] <= r_dist[k-1];
        end
    end

    assign o_distance = r_dist[snss_pkg::DIST_DLY-1];

    `SNSS_ASSERT_IMPL(a_div_lanes, i_clk, i_rst_n, 1'b1, o_done == w_v_done, "quotient lanes out of step")
    `SNSS_ASSERT_IMPL(a_gram_psd, i_clk, i_rst_n, r_v[9], !w_det_full[MW-1], "negative gram determinant")
    `SNSS_ASSERT_IMPL(a_cramer_den, i_clk, i_rst_n, r_v[snss_pkg::STG_SEL] && !r11_degen, r11_den_u != '0 && r11_den_v != '0, "zero divisor on cramer path")

endmodule
